[hw/rtl/acft_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the adaptive cumulative frequency table.
// No dependencies; every other file of the block refers to this package.
package acft_pkg;

  // Fixed field widths of the request and response channels.
  localparam int OP_W     = 2;
  localparam int SYM_W    = 8;
  localparam int CELL_W   = 8;
  localparam int TARGET_W = 16;
  localparam int OUT_W    = 16;
  localparam int STATUS_W = 2;

  // Cells per group in the first level of the collection tree.
  localparam int GRP_SIZE = 16;

  // Offset that maps a signed byte symbol onto its cell number.
  localparam logic [CELL_W-1:0] SYM_OFFSET = 8'h80;

  typedef enum logic [OP_W-1:0] {
    OP_UPDATE = 2'd0,
    OP_ENCODE = 2'd1,
    OP_DECODE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_RANGE    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                upd;
    logic                dec;
    logic [CELL_W-1:0]   addr;
    logic [TARGET_W-1:0] target;
  } cell_cmd_t;

  // Load enables of the two levels of the collection tree.
  typedef struct packed {
    logic grp_en;
    logic sel_en;
  } gather_ctl_t;

endpackage

[hw/rtl/acft_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response sides.
// Depends on acft_pkg for the field widths.
interface acft_in_if;
  logic                                valid;
  logic                                ready;
  logic [acft_pkg::OP_W-1:0]           operation;
  logic signed [acft_pkg::SYM_W-1:0]   symbol;
  logic [acft_pkg::TARGET_W-1:0]       target_count;

  modport source (output valid, operation, symbol, target_count, input ready);
  modport sink   (input valid, operation, symbol, target_count, output ready);
endinterface

interface acft_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [acft_pkg::SYM_W-1:0]   found_symbol;
  logic [acft_pkg::OUT_W-1:0]          range_low;
  logic [acft_pkg::OUT_W-1:0]          range_high;
  logic [acft_pkg::OUT_W-1:0]          range_total;
  logic                                seen_before;
  logic [acft_pkg::STATUS_W-1:0]       status;

  modport source (output valid, found_symbol, range_low, range_high, range_total,
                  seen_before, status, input ready);
  modport sink   (input valid, found_symbol, range_low, range_high, range_total,
                  seen_before, status, output ready);
endinterface

[hw/rtl/adaptive_cumulative_frequency_table_top.sv]
`timescale 1ns / 1ps
// Adaptive cumulative frequency table: one request in, at most one response out.
// An update, encode or decode request passes through S_EVAL, S_GATHER and S_DONE
// from acceptance until its response is loaded and the next request can be taken:
// in S_EVAL every cell of the chain compares and updates in parallel while the
// first level of the registered OR tree collects the selected cell's count and
// bound, in S_GATHER the second level of the tree loads, and in S_DONE the
// response is formed and loaded into the output register. The next request is
// taken in the cycle the response is loaded, provided the output register is
// free or its response is taken in that cycle; a sink that stalls longer holds
// the request side back until it takes the waiting response. A request with
// operation code 3 is taken without giving a response. Symbols are
// signed bytes ordered from -128 upwards; counts are COUNT_WIDTH bits wide and
// the response carries their low 16 bits. Reset clears all counts.
// Depends on acft_pkg, acft_if, acft_cell and acft_gather.
module adaptive_cumulative_frequency_table_top #(
  parameter int SYMBOL_COUNT = 256,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic       clk,
  input  logic       rst,
  acft_in_if.sink    in_ch,
  acft_out_if.source out_ch
);

  localparam int CW     = COUNT_WIDTH;
  localparam int WORD_W = acft_pkg::CELL_W + 2 * CW;
  localparam int CMP_W  = (CW > acft_pkg::TARGET_W) ? CW : acft_pkg::TARGET_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EVAL   = 4'b0010,
    S_GATHER = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Request registers.
  acft_pkg::op_t                     req_op;
  logic signed [acft_pkg::SYM_W-1:0] req_sym;
  logic [acft_pkg::TARGET_W-1:0]     req_target;
  logic [acft_pkg::CELL_W-1:0]       req_cell;
  logic                              in_alpha;

  logic [CW-1:0] total;
  logic          total_full;
  logic          full_q;
  logic          upd_en;
  logic          accept;
  logic          out_free;
  logic          load;

  acft_pkg::cell_cmd_t   cmd;
  acft_pkg::gather_ctl_t gctl;

  logic [CW-1:0]     uppers [SYMBOL_COUNT];
  logic [WORD_W-1:0] words  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] hits;
  logic [WORD_W-1:0] sel_word;

  logic [acft_pkg::CELL_W-1:0] sel_cell;
  logic [CW-1:0]               sel_count;
  logic [CW-1:0]               sel_upper;
  logic [CW-1:0]               sel_low;

  // Response next values and registers.
  logic signed [acft_pkg::SYM_W-1:0] rsp_sym_next;
  logic [CW-1:0]                     rsp_low_next;
  logic [CW-1:0]                     rsp_high_next;
  logic                              rsp_seen_next;
  acft_pkg::status_t                 rsp_status_next;

  logic                              out_valid;
  logic signed [acft_pkg::SYM_W-1:0] out_sym;
  logic [acft_pkg::OUT_W-1:0]        out_low;
  logic [acft_pkg::OUT_W-1:0]        out_high;
  logic [acft_pkg::OUT_W-1:0]        out_total;
  logic                              out_seen;
  acft_pkg::status_t                 out_status;

  // Handshake and request capture.
  assign out_free    = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE) || ((state == S_DONE) && out_free);
  assign accept      = in_ch.valid && in_ch.ready;
  assign load        = (state == S_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op     <= acft_pkg::op_t'(in_ch.operation);
      req_sym    <= in_ch.symbol;
      req_target <= in_ch.target_count;
    end
  end

  assign req_cell   = acft_pkg::CELL_W'(req_sym) ^ acft_pkg::SYM_OFFSET;
  assign in_alpha   = {1'b0, req_cell} < (acft_pkg::CELL_W + 1)'(SYMBOL_COUNT);
  assign total_full = (total == {CW{1'b1}});
  assign upd_en     = (state == S_EVAL) && (req_op == acft_pkg::OP_UPDATE) &&
                      in_alpha && !total_full;

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (acft_pkg::op_t'(in_ch.operation) == acft_pkg::OP_NONE)
                       ? S_IDLE : S_EVAL;
        end
      end
      S_EVAL:   state_next = S_GATHER;
      S_GATHER: state_next = S_DONE;
      S_DONE: begin
        if (accept) begin
          state_next = (acft_pkg::op_t'(in_ch.operation) == acft_pkg::OP_NONE)
                       ? S_IDLE : S_EVAL;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Total of all counts, and whether it was full when the update was tried.
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (upd_en) begin
      total <= total + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      full_q <= total_full;
    end
  end

  // Chain of cells.
  assign cmd.upd    = upd_en;
  assign cmd.dec    = (req_op == acft_pkg::OP_DECODE);
  assign cmd.addr   = req_cell;
  assign cmd.target = req_target;

  for (genvar i = 0; i < SYMBOL_COUNT; i++) begin : g_cell
    logic [CW-1:0] prev_upper;
    if (i == 0) begin : g_first
      assign prev_upper = '0;
    end else begin : g_rest
      assign prev_upper = uppers[i-1];
    end
    acft_cell #(
      .COUNT_WIDTH (CW),
      .IDX         (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .prev_upper (prev_upper),
      .upper      (uppers[i]),
      .hit        (hits[i]),
      .word       (words[i])
    );
  end

  // Collection of the selected cell's fields.
  assign gctl.grp_en = (state == S_EVAL);
  assign gctl.sel_en = (state == S_GATHER);

  acft_gather #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .WORD_W       (WORD_W)
  ) u_gather (
    .clk      (clk),
    .ctl      (gctl),
    .words    (words),
    .sel_word (sel_word)
  );

  assign sel_cell  = sel_word[WORD_W-1:2*CW];
  assign sel_count = sel_word[2*CW-1:CW];
  assign sel_upper = sel_word[CW-1:0];
  assign sel_low   = sel_upper - sel_count;

  // Response from the collected fields, taken before any update of this request.
  always_comb begin
    rsp_sym_next    = req_sym;
    rsp_low_next    = '0;
    rsp_high_next   = '0;
    rsp_seen_next   = 1'b0;
    rsp_status_next = acft_pkg::ST_OK;
    case (req_op)
      acft_pkg::OP_DECODE: begin
        if (CMP_W'(req_target) >= CMP_W'(total)) begin
          rsp_sym_next    = '0;
          rsp_status_next = acft_pkg::ST_RANGE;
        end else begin
          rsp_sym_next  = acft_pkg::SYM_W'(sel_cell ^ acft_pkg::SYM_OFFSET);
          rsp_low_next  = sel_low;
          rsp_high_next = sel_upper;
        end
      end
      acft_pkg::OP_ENCODE: begin
        if (!in_alpha || (sel_count == '0)) begin
          rsp_status_next = acft_pkg::ST_UNKNOWN;
        end else begin
          rsp_low_next  = sel_low;
          rsp_high_next = sel_upper;
        end
      end
      default: begin
        if (!in_alpha) begin
          rsp_status_next = acft_pkg::ST_UNKNOWN;
        end else if (full_q) begin
          rsp_status_next = acft_pkg::ST_OVERFLOW;
          rsp_low_next    = sel_low;
          rsp_high_next   = sel_upper;
          rsp_seen_next   = (sel_count != '0);
        end else begin
          rsp_low_next  = sel_low;
          rsp_high_next = sel_upper + CW'(1);
          rsp_seen_next = (sel_count != '0);
        end
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_sym    <= rsp_sym_next;
      out_low    <= acft_pkg::OUT_W'(rsp_low_next);
      out_high   <= acft_pkg::OUT_W'(rsp_high_next);
      out_total  <= acft_pkg::OUT_W'(total);
      out_seen   <= rsp_seen_next;
      out_status <= rsp_status_next;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.found_symbol = out_sym;
  assign out_ch.range_low    = out_low;
  assign out_ch.range_high   = out_high;
  assign out_ch.range_total  = out_total;
  assign out_ch.seen_before  = out_seen;
  assign out_ch.status       = out_status;

`ifndef ASSERT_OFF
  // A decode whose target lies below the total selects exactly one cell.
  a_decode_one_hit: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EVAL) && (req_op == acft_pkg::OP_DECODE) &&
     (CMP_W'(req_target) < CMP_W'(total))) |-> $onehot(hits))
    else $error("decode did not select exactly one cell");

  // An accepted update raises the total by exactly one.
  a_total_step: assert property (@(posedge clk) disable iff (rst)
    upd_en |=> (total == CW'($past(total) + CW'(1))))
    else $error("total did not advance by one on an update");

  // The total only moves during the evaluation cycle.
  a_total_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_EVAL) |=> $stable(total))
    else $error("total changed outside the evaluation cycle");
`endif

endmodule

[hw/rtl/acft_cell.sv]
`timescale 1ns / 1ps
// One cell of the chain: holds the count and cumulative upper bound of one symbol.
// Depends on acft_pkg for the command struct and field widths.
module acft_cell #(
  parameter int COUNT_WIDTH = 16,
  parameter int IDX         = 0
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  acft_pkg::cell_cmd_t                    cmd,
  input  logic [COUNT_WIDTH-1:0]                 prev_upper,
  output logic [COUNT_WIDTH-1:0]                 upper,
  output logic                                   hit,
  output logic [acft_pkg::CELL_W+2*COUNT_WIDTH-1:0] word
);

  localparam int CMP_W = (COUNT_WIDTH > acft_pkg::TARGET_W) ? COUNT_WIDTH
                                                             : acft_pkg::TARGET_W;
  localparam logic [acft_pkg::CELL_W-1:0] IDX_B = acft_pkg::CELL_W'(IDX);

  logic [COUNT_WIDTH-1:0] count;
  logic                   at_cell;
  logic                   past_cell;
  logic                   dec_hit;

  // Position of this cell relative to the addressed one.
  assign at_cell   = (cmd.addr == IDX_B);
  assign past_cell = (cmd.addr <= IDX_B);

  // The bounds rise along the chain, so the first range holding the target is
  // the one cell whose bound exceeds it while its left neighbour's does not.
  assign dec_hit = (CMP_W'(cmd.target) < CMP_W'(upper)) &&
                   !(CMP_W'(cmd.target) < CMP_W'(prev_upper));

  assign hit  = cmd.dec ? dec_hit : at_cell;
  assign word = hit ? {IDX_B, count, upper} : '0;

  // Count and bound update: this cell and every later one raise their bound.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      upper <= '0;
    end else if (cmd.upd) begin
      if (past_cell) begin
        upper <= upper + COUNT_WIDTH'(1);
      end
      if (at_cell) begin
        count <= count + COUNT_WIDTH'(1);
      end
    end
  end

endmodule

[hw/rtl/acft_gather.sv]
`timescale 1ns / 1ps
// Two-level registered OR tree that collects the fields of the selected cell.
// Depends on acft_pkg for the group size and the load-enable struct.
module acft_gather #(
  parameter int SYMBOL_COUNT = 256,
  parameter int WORD_W       = 40
) (
  input  logic                  clk,
  input  acft_pkg::gather_ctl_t ctl,
  input  logic [WORD_W-1:0]     words [SYMBOL_COUNT],
  output logic [WORD_W-1:0]     sel_word
);

  localparam int NGRP = (SYMBOL_COUNT + acft_pkg::GRP_SIZE - 1) / acft_pkg::GRP_SIZE;
  localparam int NPAD = NGRP * acft_pkg::GRP_SIZE;

  logic [WORD_W-1:0] pad      [NPAD];
  logic [WORD_W-1:0] grp      [NGRP];
  logic [WORD_W-1:0] grp_next [NGRP];
  logic [WORD_W-1:0] sel_next;

  // Pad the row of cells up to a whole number of groups.
  for (genvar j = 0; j < NPAD; j++) begin : g_pad
    if (j < SYMBOL_COUNT) begin : g_used
      assign pad[j] = words[j];
    end else begin : g_empty
      assign pad[j] = '0;
    end
  end

  // First level: OR within each group.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < acft_pkg::GRP_SIZE; k++) begin
        grp_next[g] = grp_next[g] | pad[g*acft_pkg::GRP_SIZE + k];
      end
    end
  end

  // Second level: OR across the registered groups.
  always_comb begin
    sel_next = '0;
    for (int g = 0; g < NGRP; g++) begin
      sel_next = sel_next | grp[g];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.grp_en) begin
      grp <= grp_next;
    end
    if (ctl.sel_en) begin
      sel_word <= sel_next;
    end
  end

endmodule

[test/tb_adaptive_cumulative_frequency_table_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the adaptive cumulative frequency table top level.
// Depends on acft_pkg, acft_if and adaptive_cumulative_frequency_table_top.
module tb_adaptive_cumulative_frequency_table_top;

  localparam int SYMBOL_COUNT = 256;
  localparam int COUNT_WIDTH  = 16;
  localparam int RANDOM_REQS  = 1600;
  localparam int QUIET_REQS   = 200;
  localparam int CYCLE_LIMIT  = 5_000_000;

  typedef struct packed {
    logic signed [acft_pkg::SYM_W-1:0] found_symbol;
    logic [acft_pkg::OUT_W-1:0]        range_low;
    logic [acft_pkg::OUT_W-1:0]        range_high;
    logic [acft_pkg::OUT_W-1:0]        range_total;
    logic                              seen_before;
    acft_pkg::status_t                 status;
  } freq_reply_t;

  // Shadow copy of the frequency table and the queue of responses it predicts.
  class freq_table_board;
    logic [COUNT_WIDTH-1:0] counts [SYMBOL_COUNT];
    logic [COUNT_WIDTH-1:0] upper  [SYMBOL_COUNT];
    logic [COUNT_WIDTH-1:0] total;
    freq_reply_t            pending [$];
    int                     errors;

    function new();
      foreach (counts[i]) begin
        counts[i] = '0;
        upper[i]  = '0;
      end
      total  = '0;
      errors = 0;
    endfunction

    // Applies one accepted request to the shadow table and queues its response.
    function void note_request(acft_pkg::op_t op, logic signed [acft_pkg::SYM_W-1:0] sym,
                               logic [acft_pkg::TARGET_W-1:0] tgt);
      logic [acft_pkg::CELL_W-1:0] cell_bits;
      int unsigned                 slot;
      freq_reply_t                 r;
      cell_bits = sym ^ acft_pkg::SYM_OFFSET;
      slot      = cell_bits;
      if (op == acft_pkg::OP_NONE) return;
      r.found_symbol = sym;
      r.range_low    = '0;
      r.range_high   = '0;
      r.seen_before  = 1'b0;
      r.status       = acft_pkg::ST_OK;
      if (op == acft_pkg::OP_DECODE) begin
        // The first cell whose upper bound lies above the target owns it.
        r.found_symbol = '0;
        r.status       = acft_pkg::ST_RANGE;
        if (tgt < total) begin
          for (int i = 0; i < SYMBOL_COUNT; i++) begin
            if (tgt < upper[i]) begin
              r.found_symbol = i[acft_pkg::CELL_W-1:0] ^ acft_pkg::SYM_OFFSET;
              r.range_low    = acft_pkg::OUT_W'(upper[i] - counts[i]);
              r.range_high   = acft_pkg::OUT_W'(upper[i]);
              r.status       = acft_pkg::ST_OK;
              break;
            end
          end
        end
      end else if (slot >= SYMBOL_COUNT) begin
        r.status = acft_pkg::ST_UNKNOWN;
      end else if (op == acft_pkg::OP_ENCODE) begin
        if (counts[slot] == '0) begin
          r.status = acft_pkg::ST_UNKNOWN;
        end else begin
          r.range_low  = acft_pkg::OUT_W'(upper[slot] - counts[slot]);
          r.range_high = acft_pkg::OUT_W'(upper[slot]);
        end
      end else begin
        // Update: refused once the total is saturated, otherwise one more
        // count for this cell and every bound from it upwards.
        r.seen_before = (counts[slot] != '0);
        if (total == '1) begin
          r.status = acft_pkg::ST_OVERFLOW;
        end else begin
          counts[slot] = counts[slot] + 1'b1;
          for (int i = slot; i < SYMBOL_COUNT; i++) upper[i] = upper[i] + 1'b1;
          total = total + 1'b1;
        end
        r.range_low  = acft_pkg::OUT_W'(upper[slot] - counts[slot]);
        r.range_high = acft_pkg::OUT_W'(upper[slot]);
      end
      r.range_total = acft_pkg::OUT_W'(total);
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Checks one accepted response against the oldest prediction.
    function void check_response(freq_reply_t got);
      freq_reply_t want;
      if (pending.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("found_symbol", want.found_symbol, got.found_symbol);
      compare_field("range_low", want.range_low, got.range_low);
      compare_field("range_high", want.range_high, got.range_high);
      compare_field("range_total", want.range_total, got.range_total);
      compare_field("seen_before", want.seen_before, got.seen_before);
      compare_field("status", want.status, got.status);
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle_count;
  int   stall_left;
  bit   src_idle_on;
  bit   sink_idle_on;

  logic signed [acft_pkg::SYM_W-1:0] hot_symbols [12];
  freq_table_board                   board;

  acft_in_if  in_ch();
  acft_out_if out_ch();

  adaptive_cumulative_frequency_table_top #(
    .SYMBOL_COUNT(SYMBOL_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Clock generation and run-away guard.
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Response side back-pressure in bursts of random length, only while sink idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
      stall_left   <= $urandom_range(0, 6);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Response monitor.
  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      board.check_response('{found_symbol: out_ch.found_symbol,
                             range_low:    out_ch.range_low,
                             range_high:   out_ch.range_high,
                             range_total:  out_ch.range_total,
                             seen_before:  out_ch.seen_before,
                             status:       acft_pkg::status_t'(out_ch.status)});
    end
  end

  // Presents one request, with an occasional gap ahead of it, and holds it
  // until it is taken. Valid stays high for a directly following request.
  task automatic send_request(acft_pkg::op_t op, logic signed [acft_pkg::SYM_W-1:0] sym,
                              logic [acft_pkg::TARGET_W-1:0] tgt);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.symbol       <= sym;
    in_ch.target_count <= tgt;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_request(op, sym, tgt);
  endtask

  // Stops sending until every predicted response has been seen.
  task automatic drain_responses();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending.size() != 0);
  endtask

  // Mostly symbols from a small working set so that encodes find them.
  function automatic logic signed [acft_pkg::SYM_W-1:0] pick_symbol();
    if ($urandom_range(0, 9) < 7) return hot_symbols[$urandom_range(0, 11)];
    return acft_pkg::SYM_W'($urandom);
  endfunction

  // Mostly targets inside the table, some at its edge and some anywhere.
  function automatic logic [acft_pkg::TARGET_W-1:0] pick_target();
    int r;
    r = $urandom_range(0, 99);
    if (board.total == '0 || r < 10) return acft_pkg::TARGET_W'($urandom);
    if (r < 20) begin
      return acft_pkg::TARGET_W'(board.total) +
             acft_pkg::TARGET_W'($urandom_range(0, 2)) - 1'b1;
    end
    return acft_pkg::TARGET_W'($urandom_range(0, board.total - 1));
  endfunction

  initial begin
    acft_pkg::op_t op;
    int            r;

    board              = new();
    clk                = 1'b0;
    rst                = 1'b1;
    cycle_count        = 0;
    stall_left         = 0;
    src_idle_on        = 1'b1;
    sink_idle_on       = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.operation    = acft_pkg::OP_NONE;
    in_ch.symbol       = '0;
    in_ch.target_count = '0;
    out_ch.ready       = 1'b0;
    foreach (hot_symbols[i]) hot_symbols[i] = acft_pkg::SYM_W'($urandom);
    hot_symbols[0] = -8'sd128;
    hot_symbols[1] = 8'sd127;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table: every decode is out of range, every encode unknown.
    send_request(acft_pkg::OP_DECODE, 8'sd0, 16'h0000);
    send_request(acft_pkg::OP_DECODE, 8'sd0, 16'hFFFF);
    send_request(acft_pkg::OP_ENCODE, -8'sd128, 16'h0000);
    send_request(acft_pkg::OP_ENCODE, 8'sd127, 16'h0000);
    // First and repeated updates at both ends of the alphabet and the middle.
    send_request(acft_pkg::OP_UPDATE, -8'sd128, 16'h0000);
    send_request(acft_pkg::OP_UPDATE, 8'sd127, 16'h0000);
    send_request(acft_pkg::OP_UPDATE, 8'sd0, 16'h0000);
    send_request(acft_pkg::OP_UPDATE, -8'sd1, 16'h0000);
    send_request(acft_pkg::OP_UPDATE, -8'sd128, 16'h0000);
    send_request(acft_pkg::OP_NONE, 8'sh55, 16'hAAAA);
    send_request(acft_pkg::OP_ENCODE, -8'sd128, 16'h0000);
    send_request(acft_pkg::OP_ENCODE, 8'sd127, 16'h0000);
    send_request(acft_pkg::OP_ENCODE, 8'sd1, 16'h0000);
    // Decodes across the bounds, up to a target equal to the total.
    send_request(acft_pkg::OP_DECODE, 8'sd0, 16'h0000);
    send_request(acft_pkg::OP_DECODE, 8'sd0, 16'h0001);
    send_request(acft_pkg::OP_DECODE, 8'sd0, 16'h0002);
    send_request(acft_pkg::OP_DECODE, 8'sd0, 16'h0003);
    send_request(acft_pkg::OP_DECODE, 8'sd0, 16'h0004);
    send_request(acft_pkg::OP_DECODE, 8'sd0, 16'h0005);
    send_request(acft_pkg::OP_UPDATE, 8'sh55, 16'hAAAA);
    send_request(acft_pkg::OP_ENCODE, -8'sh56, 16'h5555);

    // Random mix of operations, with stretches free of idling on each side
    // and no idling at all in the closing stretch.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n >= RANDOM_REQS - QUIET_REQS) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end else begin
        src_idle_on  = ((n / 200) % 4 != 3);
        sink_idle_on = ((n / 200) % 4 != 1);
      end
      if (n == RANDOM_REQS / 2) drain_responses();
      r = $urandom_range(0, 99);
      if (r < 40)      op = acft_pkg::OP_UPDATE;
      else if (r < 65) op = acft_pkg::OP_ENCODE;
      else if (r < 95) op = acft_pkg::OP_DECODE;
      else             op = acft_pkg::OP_NONE;
      send_request(op, pick_symbol(), pick_target());
    end

    drain_responses();
    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[adaptive_cumulative_frequency_table_top.f]
hw/rtl/acft_pkg.sv
hw/rtl/acft_if.sv
hw/rtl/acft_cell.sv
hw/rtl/acft_gather.sv
hw/rtl/adaptive_cumulative_frequency_table_top.sv
test/tb_adaptive_cumulative_frequency_table_top.sv
